FILE: sv/ssr_pkg.sv
package ssr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LENGTH      = 2'd0,
        REG_NEEDLE_PATTERN     = 2'd1,
        REG_REPLACEMENT_LENGTH = 2'd2,
        REG_REPLACEMENT_TEXT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

FILE: sv/ssr_cell.sv
module ssr_cell (
    input  logic                        i_clk,
    input  ssr_pkg::t_cell_ctl          i_ctl,
    input  logic [ssr_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic [ssr_pkg::BYTE_W-1:0]  i_shift_byte,
    input  logic [ssr_pkg::BYTE_W-1:0]  i_needle_byte,
    output logic [ssr_pkg::BYTE_W-1:0]  o_byte,
    output logic                        o_eq
);

    logic [ssr_pkg::BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_in_byte;
        end else if (i_ctl.shift) begin
            r_byte <= i_shift_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = (r_byte == i_needle_byte);

endmodule

FILE: sv/ssr_emit.sv
module ssr_emit #(
    parameter int BURST = 8,
    parameter int NW    = $clog2(BURST + 1)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic [BURST-1:0][ssr_pkg::BYTE_W-1:0]  i_bytes,
    input  logic [NW-1:0]                          i_count,
    input  logic                                   i_bare,
    input  logic                                   i_end,
    output logic                                   o_can_take,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [ssr_pkg::BYTE_W-1:0]             o_out_byte,
    output logic                                   o_out_has_byte,
    output logic                                   o_out_end
);

    localparam int IW = $clog2(BURST);

    logic                                  r_busy;
    logic [BURST-1:0][ssr_pkg::BYTE_W-1:0] r_bytes;
    logic [IW-1:0]                         r_idx;
    logic [IW-1:0]                         r_last_idx;
    logic                                  r_bare;
    logic                                  r_end;
    logic                                  w_out_acc;
    logic                                  w_last;

    assign w_last     = (r_idx == r_last_idx);
    assign w_out_acc  = r_busy & ~i_out_stall;
    assign o_can_take = ~r_busy | (w_out_acc & w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy     <= 1'b1;
            r_idx      <= '0;
            r_bytes    <= i_bytes;
            r_last_idx <= IW'(i_count - NW'(1));
            r_bare     <= i_bare;
            r_end      <= i_end;
        end else if (w_out_acc) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    assign o_out_valid    = r_busy;
    assign o_out_byte     = r_bare ? '0 : r_bytes[r_idx];
    assign o_out_has_byte = ~r_bare;
    assign o_out_end      = r_end & w_last;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_take)
        else $error("burst loaded while previous burst still pending");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !w_last) |=> r_busy)
        else $error("burst ended before its last item");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last_idx))
        else $error("burst index past its last item");

endmodule

FILE: sv/stream_substring_replace.sv
// streaming substring replace
// input channel: i_in_valid / o_in_stall carry one item per cycle when not
// stalled: a byte, a has-byte flag and an end-of-string flag. output
// channel: o_out_valid / i_out_stall carry result items of the same form.
// config: i_cfg_wr_en, i_cfg_index, i_cfg_data write needle length (0),
// needle pattern (1), replacement length (2), replacement text (3); the
// user must write only while idle; the block does not enforce it. writing
// needle length drops any held bytes. a row of window cells holds up to
// needle length - 1 bytes; each cell compares its byte with its needle
// byte, and the cells shift toward the front when the oldest byte is passed
// on. an item's first result appears the cycle after it is taken. the block
// takes one item per cycle while each item yields at most one result and
// the receiver does not stall. an item that yields n results (a match with
// replacement length n, or a string end flushing the window) keeps the
// single output register busy and the input stalled until all n are out.
// reset: config registers go to zero (pass-through), window and output empty.
// while the receiver stalls, the current result holds and the input stalls
// for as long as a result is waiting.
module stream_substring_replace #(
    parameter int MAX_NEEDLE_BYTES      = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ssr_pkg::BYTE_W-1:0]        i_in_byte,
    input  logic                              i_in_has_byte,
    input  logic                              i_in_end,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ssr_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_out_has_byte,
    output logic                              o_out_end
);

    localparam int NEEDLE_CAP = (MAX_NEEDLE_BYTES < 8) ? MAX_NEEDLE_BYTES : 8;
    localparam int REPL_CAP   = (MAX_REPLACEMENT_BYTES < 8) ? MAX_REPLACEMENT_BYTES : 8;
    localparam int CELLS      = NEEDLE_CAP - 1;
    localparam int BURST      = (NEEDLE_CAP > REPL_CAP) ? NEEDLE_CAP : REPL_CAP;
    localparam int CW         = $clog2(NEEDLE_CAP);
    localparam int NW         = $clog2(BURST + 1);
    localparam int LW         = ssr_pkg::LEN_W;
    localparam int BW         = ssr_pkg::BYTE_W;

    logic [LW-1:0]                 r_needle_len;
    logic [ssr_pkg::CFG_DATA_W-1:0] r_needle_pat;
    logic [LW-1:0]                 r_repl_len;
    logic [ssr_pkg::CFG_DATA_W-1:0] r_repl_text;
    logic [CW-1:0]                 r_count;

    logic [LW-1:0]                 w_len;
    logic [LW-1:0]                 w_rlen;
    logic [LW-1:0]                 w_count_ext;
    logic [2:0]                    w_last_idx;
    logic                          w_pass;
    logic                          w_fill;
    logic                          w_prefix_eq;
    logic                          w_last_eq;
    logic                          w_match;
    logic                          w_miss;
    logic                          w_append;
    logic                          w_accept;
    logic                          w_can_take;
    logic [NW-1:0]                 w_n;
    logic [NW-1:0]                 w_n_out;
    logic                          w_bare;
    logic [CW-1:0]                 w_load_pos;
    logic [BW-1:0]                 w_cell_byte [CELLS];
    logic [CELLS-1:0]              w_cell_eq;
    logic [BURST-1:0][BW-1:0]      w_bytes;

    assign w_len  = (r_needle_len > LW'(NEEDLE_CAP)) ? LW'(NEEDLE_CAP) : r_needle_len;
    assign w_rlen = (r_repl_len > LW'(REPL_CAP)) ? LW'(REPL_CAP) : r_repl_len;

    assign w_count_ext = LW'(r_count);
    assign w_pass      = (w_len == '0);
    assign w_fill      = ((w_count_ext + LW'(1)) == w_len);
    assign w_last_idx  = 3'(w_len - LW'(1));
    assign w_last_eq   = (i_in_byte == r_needle_pat[{w_last_idx, 3'b000} +: BW]);

    always_comb begin
        w_prefix_eq = 1'b1;
        for (int i = 0; i < CELLS; i++) begin
            w_prefix_eq = w_prefix_eq & (w_cell_eq[i] | (CW'(i) >= r_count));
        end
    end

    assign w_match  = i_in_has_byte & ~w_pass & w_fill & w_prefix_eq & w_last_eq;
    assign w_miss   = i_in_has_byte & ~w_pass & w_fill & ~w_match;
    assign w_append = i_in_has_byte & ~w_pass & ~w_match;

    always_comb begin
        priority if (w_match) begin
            w_n = NW'(w_rlen);
        end else if (i_in_end) begin
            w_n = NW'(r_count) + NW'(i_in_has_byte);
        end else if (i_in_has_byte && (w_pass || w_fill)) begin
            w_n = NW'(1);
        end else begin
            w_n = '0;
        end
    end

    assign w_bare  = i_in_end & (w_n == '0);
    assign w_n_out = w_bare ? NW'(1) : w_n;

    assign w_accept   = i_in_valid & w_can_take;
    assign o_in_stall = ~w_can_take;
    assign w_load_pos = w_miss ? (r_count - CW'(1)) : r_count;

    // window cells
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        ssr_pkg::t_cell_ctl w_ctl;
        logic [BW-1:0]      w_shift_byte;

        assign w_ctl.load  = w_accept & w_append & (w_load_pos == CW'(g));
        assign w_ctl.shift = w_accept & w_miss;

        if (g + 1 < CELLS) begin : g_mid
            assign w_shift_byte = w_cell_byte[g+1];
        end else begin : g_tail
            assign w_shift_byte = i_in_byte;
        end

        ssr_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_in_byte     (i_in_byte),
            .i_shift_byte  (w_shift_byte),
            .i_needle_byte (r_needle_pat[g*BW +: BW]),
            .o_byte        (w_cell_byte[g]),
            .o_eq          (w_cell_eq[g])
        );
    end

    // result bytes: replacement on a match, else held bytes then the new byte
    for (genvar k = 0; k < BURST; k++) begin : g_burst
        if (k < CELLS) begin : g_win
            assign w_bytes[k] = w_match ? r_repl_text[k*BW +: BW] :
                                ((CW'(k) < r_count) ? w_cell_byte[k] : i_in_byte);
        end else begin : g_new
            assign w_bytes[k] = w_match ? r_repl_text[k*BW +: BW] : i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_len <= '0;
            r_needle_pat <= '0;
            r_repl_len   <= '0;
            r_repl_text  <= '0;
            r_count      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (ssr_pkg::t_reg_idx'(i_cfg_index))
                ssr_pkg::REG_NEEDLE_LENGTH: begin
                    r_needle_len <= i_cfg_data[LW-1:0];
                    r_count      <= '0;
                end
                ssr_pkg::REG_NEEDLE_PATTERN:     r_needle_pat <= i_cfg_data;
                ssr_pkg::REG_REPLACEMENT_LENGTH: r_repl_len   <= i_cfg_data[LW-1:0];
                ssr_pkg::REG_REPLACEMENT_TEXT:   r_repl_text  <= i_cfg_data;
                default: ;
            endcase
        end else if (w_accept) begin
            priority if (i_in_end || w_match) begin
                r_count <= '0;
            end else if (w_append && !w_miss) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

    ssr_emit #(
        .BURST (BURST),
        .NW    (NW)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept & (w_n_out != '0)),
        .i_bytes        (w_bytes),
        .i_count        (w_n_out),
        .i_bare         (w_bare),
        .i_end          (i_in_end),
        .o_can_take     (w_can_take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_has_byte (o_out_has_byte),
        .o_out_end      (o_out_end)
    );

    a_pass_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pass |-> (r_count == '0))
        else $error("window holds bytes in pass-through");

    a_window_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pass |-> (w_count_ext < w_len))
        else $error("window reached needle length");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_end && !i_cfg_wr_en) |=> (r_count == '0))
        else $error("window not flushed at string end");

endmodule
